/* src/scancode_to_ascii_fifo_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the scancode to ASCII FIFO core
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_FIFO_CORE_ASSERT_SVH
`define SCANCODE_TO_ASCII_FIFO_CORE_ASSERT_SVH

// Concurrent assertion with an explicit clock and active-low reset
`define SC2A_ASSERT_RST(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error(msg);

// Concurrent assertion on the local clk and rst_n
`define SC2A_ASSERT(lbl, prop, msg) \
    `SC2A_ASSERT_RST(lbl, clk, rst_n, prop, msg)

`endif

/* src/sc2a_pkg.sv */
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared constants and decode tables for the scancode to ASCII FIFO core.
// ----------------------------------------------------------------------------
package sc2a_pkg;

    // Request operation codes
    localparam logic OP_SCANCODE = 1'b0;
    localparam logic OP_POP      = 1'b1;

    // Field widths
    localparam int SCAN_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int COUNT_W = 8;

    // Default FIFO depth (holds one entry less)
    localparam int FIFO_DEPTH_DEF = 256;

    // Set 1 key codes
    localparam logic [6:0] KEY_LSHIFT   = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT   = 7'h36;
    localparam logic [7:0] KEY_CAPSLOCK = 8'h3A;
    localparam logic [7:0] CODE_COUNT   = 8'd58;

    // Lower-case letter bounds and case offset
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 7'd32;

    typedef logic [CHAR_W-1:0] char_t;

    // Unshifted US layout, padded to 64 slots with zeros
    localparam char_t PLAIN_MAP [64] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // Shifted US layout, padded to 64 slots with zeros
    localparam char_t SHIFT_MAP [64] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

/* src/sc2a_req_if.sv */
// ----------------------------------------------------------------------------
// sc2a_req_if
// Request channel: a scancode byte or a pop, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sc2a_req_if;
    import sc2a_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [SCAN_W-1:0] scancode;

    modport source (output valid, output operation, output scancode, input ready);
    modport sink   (input valid, input operation, input scancode, output ready);
endinterface

/* src/sc2a_rsp_if.sv */
// ----------------------------------------------------------------------------
// sc2a_rsp_if
// Result channel: popped character and keyboard status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sc2a_rsp_if;
    import sc2a_pkg::*;

    logic               valid;
    logic               ready;
    logic               char_valid;
    logic [CHAR_W-1:0]  character;
    logic [COUNT_W-1:0] chars_waiting;
    logic               shift_active;
    logic               caps_active;

    modport source (
        output valid, output char_valid, output character, output chars_waiting,
        output shift_active, output caps_active, input ready
    );
    modport sink (
        input valid, input char_valid, input character, input chars_waiting,
        input shift_active, input caps_active, output ready
    );
endinterface

/* src/scancode_to_ascii_fifo_core.sv */
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_core
// Set 1 scancode decoder (US layout) feeding a ring FIFO of characters.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per handshake: operation 0 delivers a raw set 1
//   scancode byte, operation 1 pops the oldest character. rsp returns exactly
//   one result per request: char_valid/character for a pop (0/0 when the
//   FIFO is empty or for a scancode), plus the FIFO fill and the shift and
//   caps lock flags after that request.
//   The result of a request is registered and shown at rsp in the cycle after
//   it is accepted. A request can be accepted every cycle while rsp takes each
//   result; the character comes straight from the registered read port of the
//   store, which is read in the cycle the pop is accepted.
//   The FIFO holds FIFO_DEPTH-1 characters; a character decoded while it is
//   full is dropped. chars_waiting saturates at 255.
//   Reset clears the pointers and both flags; the store itself is not
//   cleared and needs no clearing pass.
//   When rsp stalls with a result held, req.ready drops until it is taken.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_core #(
    parameter int FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sc2a_req_if.sink    req,
    sc2a_rsp_if.source  rsp
);
    import sc2a_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CW    = (PTR_W + 1 > COUNT_W + 1) ? PTR_W + 1 : COUNT_W + 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next, rd_ptr_inc;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic               shift_reg, shift_next;
    logic               caps_reg, caps_next;
    logic               out_valid_reg, out_valid_next;
    logic               pop_hit_reg;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               accept, is_pop, fifo_empty, fifo_full;
    logic               do_pop, do_push;
    logic               is_break, shift_key, caps_key, in_range;
    logic [5:0]         code_idx;
    char_t              plain_ch, shifted_ch, cased_ch, dec_ch;
    logic               is_letter, push_char;
    logic [CW-1:0]      diff_raw, diff_full;
    char_t              ram_rdata;

    // Handshake: take a request whenever the result slot is free or draining
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_pop    = (req.operation == OP_POP);

    // Ring pointer arithmetic
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign fifo_empty = (rd_ptr_reg == wr_ptr_reg);
    assign fifo_full  = (wr_ptr_inc == rd_ptr_reg);

    // Decode the scancode byte
    assign is_break  = req.scancode[7];
    assign shift_key = (req.scancode[6:0] == KEY_LSHIFT) ||
                       (req.scancode[6:0] == KEY_RSHIFT);
    assign caps_key  = (req.scancode == KEY_CAPSLOCK);
    assign in_range  = (req.scancode < CODE_COUNT);
    assign code_idx  = req.scancode[5:0];

    assign plain_ch   = PLAIN_MAP[code_idx];
    assign shifted_ch = SHIFT_MAP[code_idx];
    assign is_letter  = (plain_ch >= CHAR_LOWER_A) && (plain_ch <= CHAR_LOWER_Z);
    assign cased_ch   = (caps_reg && is_letter) ? plain_ch - CASE_OFFSET : plain_ch;
    assign dec_ch     = shift_reg ? shifted_ch : cased_ch;

    assign push_char = !is_break && !shift_key && !caps_key && in_range &&
                       (dec_ch != '0);

    assign do_pop  = accept && is_pop && !fifo_empty;
    assign do_push = accept && !is_pop && push_char && !fifo_full;

    // Advance pointers
    assign rd_ptr_next = do_pop  ? rd_ptr_inc : rd_ptr_reg;
    assign wr_ptr_next = do_push ? wr_ptr_inc : wr_ptr_reg;

    // Update keyboard flags
    always_comb
    begin
        shift_next = shift_reg;
        caps_next  = caps_reg;
        if (accept && !is_pop)
        begin
            if (is_break && shift_key)
            begin
                shift_next = 1'b0;
            end
            else if (!is_break && shift_key)
            begin
                shift_next = 1'b1;
            end
            else if (caps_key)
            begin
                caps_next = !caps_reg;
            end
        end
    end

    // Fill count after this request, saturated to the field width
    assign diff_raw  = CW'(wr_ptr_next) - CW'(rd_ptr_next);
    assign diff_full = (wr_ptr_next >= rd_ptr_next) ? diff_raw
                                                    : diff_raw + CW'(FIFO_DEPTH);
    assign count_next = (diff_full > CW'({COUNT_W{1'b1}})) ? {COUNT_W{1'b1}}
                                                           : diff_full[COUNT_W-1:0];

    // Hold a result until taken
    assign out_valid_next = accept ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            shift_reg     <= 1'b0;
            caps_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            shift_reg     <= shift_next;
            caps_reg      <= caps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_hit_reg <= do_pop;
            count_reg   <= count_next;
        end
    end

    // Character store
    sc2a_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_push),
        .waddr (wr_ptr_reg),
        .wdata (dec_ch),
        .re    (do_pop),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Drive the result channel
    assign rsp.valid         = out_valid_reg;
    assign rsp.char_valid    = pop_hit_reg;
    assign rsp.character     = pop_hit_reg ? ram_rdata : '0;
    assign rsp.chars_waiting = count_reg;
    assign rsp.shift_active  = shift_reg;
    assign rsp.caps_active   = caps_reg;
endmodule

/* src/sc2a_ram.sv */
// ----------------------------------------------------------------------------
// sc2a_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module sc2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* src/sc2a_checker.sv */
// ----------------------------------------------------------------------------
// sc2a_checker
// Port-level checks for the scancode to ASCII FIFO core, bound to the top.
// ----------------------------------------------------------------------------
`include "scancode_to_ascii_fifo_core_assert.svh"

module sc2a_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_char_valid,
    input logic [sc2a_pkg::CHAR_W-1:0] rsp_character
);
    import sc2a_pkg::*;

    // Every accepted request yields a result in the next cycle
    `SC2A_ASSERT(a_req_gives_rsp, (req_valid && req_ready) |=> rsp_valid, "request lost")

    // A popped character is never the null code
    `SC2A_ASSERT(a_pop_nonzero, (rsp_valid && rsp_char_valid) |-> (rsp_character != '0), "null char popped")

    // No character reported unless a pop returned one
    `SC2A_ASSERT(a_no_char_zero, (rsp_valid && !rsp_char_valid) |-> (rsp_character == '0), "stray character")

    // A stalled result holds
    `SC2A_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_character) && $stable(rsp_char_valid)), "stalled result changed")
endmodule

bind scancode_to_ascii_fifo_core sc2a_checker u_sc2a_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_char_valid (rsp.char_valid),
    .rsp_character  (rsp.character)
);
